// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted
`define R2OK_ASSERT(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) \
		else $error("r2ok assertion failed");

// Clocked property, checked during reset as well
`define R2OK_ASSERT_ALWAYS(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) prop) \
		else $error("r2ok assertion failed");

`endif

// ----- sv/r2ok_pkg.sv -----
// ----------------------------------------------------------------------------
// r2ok_pkg
// Fixed-point formats and matrix coefficients of the linear RGB to Oklab path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package r2ok_pkg;

	localparam int LMS_FRAC   = 30;
	localparam int LMS_COEF_W = 30;
	localparam int CONE_W     = 60;
	localparam int ROOT_W     = 20;
	localparam int LAB_COEF_W = 31;
	localparam int LAB_PROD_W = LAB_COEF_W + ROOT_W + 1;
	localparam int LAB_SUM_W  = LAB_PROD_W + 2;
	localparam int OUT_W      = 16;

	typedef logic [LMS_COEF_W-1:0]        lms_coef_t;
	typedef logic signed [LAB_COEF_W-1:0] lab_coef_t;
	typedef logic [CONE_W-1:0]            cone_t;
	typedef logic [ROOT_W-1:0]            root_t;

	localparam logic [63:0] DEC_SCALE = 64'd10000000000;
	localparam logic [63:0] DEC_HALF  = 64'd5000000000;

	// LMS matrix, Q0.30, rounded to nearest
	localparam lms_coef_t LMS_MAT [3][3] = '{
		'{LMS_COEF_W'(((64'd4122214708 << LMS_FRAC) + DEC_HALF) / DEC_SCALE),
		  LMS_COEF_W'(((64'd5363325363 << LMS_FRAC) + DEC_HALF) / DEC_SCALE),
		  LMS_COEF_W'(((64'd514459929 << LMS_FRAC) + DEC_HALF) / DEC_SCALE)},
		'{LMS_COEF_W'(((64'd2119034982 << LMS_FRAC) + DEC_HALF) / DEC_SCALE),
		  LMS_COEF_W'(((64'd6806995451 << LMS_FRAC) + DEC_HALF) / DEC_SCALE),
		  LMS_COEF_W'(((64'd1073969566 << LMS_FRAC) + DEC_HALF) / DEC_SCALE)},
		'{LMS_COEF_W'(((64'd883024619 << LMS_FRAC) + DEC_HALF) / DEC_SCALE),
		  LMS_COEF_W'(((64'd2817188376 << LMS_FRAC) + DEC_HALF) / DEC_SCALE),
		  LMS_COEF_W'(((64'd6299787005 << LMS_FRAC) + DEC_HALF) / DEC_SCALE)}
	};

	// Lab matrix, signed Q.28, rounded to nearest
	localparam lab_coef_t LAB_MAT [3][3] = '{
		'{LAB_COEF_W'(((64'd2104542553 << 28) + DEC_HALF) / DEC_SCALE),
		  LAB_COEF_W'(((64'd7936177850 << 28) + DEC_HALF) / DEC_SCALE),
		  LAB_COEF_W'(64'd0 - (((64'd40720468 << 28) + DEC_HALF) / DEC_SCALE))},
		'{LAB_COEF_W'(((64'd19779984951 << 28) + DEC_HALF) / DEC_SCALE),
		  LAB_COEF_W'(64'd0 - (((64'd24285922050 << 28) + DEC_HALF) / DEC_SCALE)),
		  LAB_COEF_W'(((64'd4505937099 << 28) + DEC_HALF) / DEC_SCALE)},
		'{LAB_COEF_W'(((64'd259040371 << 28) + DEC_HALF) / DEC_SCALE),
		  LAB_COEF_W'(((64'd7827717612 << 28) + DEC_HALF) / DEC_SCALE),
		  LAB_COEF_W'(64'd0 - (((64'd8086757983 << 28) + DEC_HALF) / DEC_SCALE))}
	};

endpackage

// ----- sv/r2ok_rgb_if.sv -----
// ----------------------------------------------------------------------------
// r2ok_rgb_if
// Valid/ready channel carrying one linear RGB pixel per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface r2ok_rgb_if #(parameter int CHANNEL_BITS = 16);
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] red;
	logic [CHANNEL_BITS-1:0] green;
	logic [CHANNEL_BITS-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ----- sv/r2ok_lab_if.sv -----
// ----------------------------------------------------------------------------
// r2ok_lab_if
// Valid/ready channel carrying one Oklab pixel per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface r2ok_lab_if;
	logic               valid;
	logic               ready;
	logic [15:0]        lightness;
	logic signed [15:0] green_red_axis;
	logic signed [15:0] blue_yellow_axis;

	modport source (output valid, output lightness, output green_red_axis,
		output blue_yellow_axis, input ready);
	modport sink (input valid, input lightness, input green_red_axis,
		input blue_yellow_axis, output ready);
endinterface

// ----- sv/rgb_to_oklab_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_oklab_converter
// Linear RGB pixel stream to Oklab L, a, b.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock while the output is not stalled. The pipeline
// has two stages for the LMS matrix, twenty for the cube root (one root bit
// per stage across all three cones) and two for the Lab matrix, whose last
// register is the output register. The whole pipeline holds as one while a
// finished result waits, so ready follows the output side combinationally.
// No state is kept between pixels.
`timescale 1ns / 1ps

module rgb_to_oklab_converter
	import r2ok_pkg::*;
#(
	parameter int CHANNEL_BITS = 16
) (
	input logic         clk,
	input logic         arst_n,
	r2ok_rgb_if.sink    rgb,
	r2ok_lab_if.source  lab
);

	logic  adv;
	logic  cone_valid;
	cone_t cone [3];
	logic  root_valid;
	root_t root [3];
	logic  lab_valid;

	// Advance whenever the output register is empty or being drained
	assign adv       = !lab_valid || lab.ready;
	assign rgb.ready = adv;
	assign lab.valid = lab_valid;

	r2ok_lms_matrix #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_lms (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (rgb.valid),
		.red       (rgb.red),
		.green     (rgb.green),
		.blue      (rgb.blue),
		.out_valid (cone_valid),
		.cone      (cone)
	);

	r2ok_cbrt_pipe u_cbrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (cone_valid),
		.cone      (cone),
		.out_valid (root_valid),
		.root      (root)
	);

	r2ok_lab_matrix u_labm (
		.clk              (clk),
		.arst_n           (arst_n),
		.adv              (adv),
		.in_valid         (root_valid),
		.root             (root),
		.out_valid        (lab_valid),
		.lightness        (lab.lightness),
		.green_red_axis   (lab.green_red_axis),
		.blue_yellow_axis (lab.blue_yellow_axis)
	);

endmodule

// ----- sv/r2ok_lms_matrix.sv -----
// ----------------------------------------------------------------------------
// r2ok_lms_matrix
// RGB to LMS cone responses: products in stage 1, sum, align and clamp in 2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module r2ok_lms_matrix
	import r2ok_pkg::*;
#(
	parameter int CHANNEL_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_valid,
	input  logic [CHANNEL_BITS-1:0] red,
	input  logic [CHANNEL_BITS-1:0] green,
	input  logic [CHANNEL_BITS-1:0] blue,
	output logic                    out_valid,
	output cone_t                   cone [3]
);

	localparam int PROD_W  = LMS_COEF_W + CHANNEL_BITS;
	localparam int SUM_W   = PROD_W + 2;
	localparam int SHIFT   = LMS_FRAC - CHANNEL_BITS;
	localparam int ALIGN_W = SUM_W + SHIFT;

	logic [CHANNEL_BITS-1:0] chan [3];
	logic [PROD_W-1:0]       prod_s1 [3][3];
	logic                    valid_s1;
	logic [SUM_W-1:0]        sum [3];
	logic [ALIGN_W-1:0]      aligned [3];
	cone_t                   cone_s2 [3];
	logic                    valid_s2;

	assign chan[0] = red;
	assign chan[1] = green;
	assign chan[2] = blue;

	// Advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: one multiplier per coefficient
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s1[i][j] <= PROD_W'(LMS_MAT[i][j]) * PROD_W'(chan[j]);
				end
			end
		end
	end

	// Stage 2: sum rows, align to Q0.60, clamp to the cone range
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = SUM_W'(prod_s1[i][0]) + SUM_W'(prod_s1[i][1]) + SUM_W'(prod_s1[i][2]);
			aligned[i] = ALIGN_W'(sum[i]) << SHIFT;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (aligned[i][ALIGN_W-1:CONE_W] != '0) begin
					cone_s2[i] <= '1;
				end else begin
					cone_s2[i] <= aligned[i][CONE_W-1:0];
				end
			end
		end
	end

	assign out_valid = valid_s2;
	assign cone      = cone_s2;

endmodule

// ----- sv/r2ok_cbrt_pipe.sv -----
// ----------------------------------------------------------------------------
// r2ok_cbrt_pipe
// Digit-by-digit cube root of three cones, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module r2ok_cbrt_pipe
	import r2ok_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  in_valid,
	input  cone_t cone [3],
	output logic  out_valid,
	output root_t root [3]
);

	localparam int REM_W  = 2 * ROOT_W + 2;
	localparam int EXT_W  = REM_W + 3;
	localparam int SQ_W   = 2 * ROOT_W;
	localparam int TRY_W  = SQ_W + 2;
	localparam int BND_W  = TRY_W + 2;

	// Stage k holds the partial root after k bits
	cone_t              x_st   [ROOT_W+1][3];
	logic [REM_W-1:0]   rem_st [ROOT_W+1][3];
	root_t              y_st   [ROOT_W+1][3];
	logic [SQ_W-1:0]    sq_st  [ROOT_W+1][3];
	logic [ROOT_W:0]    vld_st;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			x_st[0][l]   = cone[l];
			rem_st[0][l] = '0;
			y_st[0][l]   = '0;
			sq_st[0][l]  = '0;
		end
	end
	assign vld_st[0] = in_valid;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic [EXT_W-1:0] rem_ext [3];
		logic [TRY_W-1:0] base    [3];
		logic [BND_W-1:0] bound   [3];
		logic             take    [3];

		// Bring down three bits, test 3*(2y)*(2y+1)+1 against the remainder
		always_comb begin
			for (int l = 0; l < 3; l++) begin
				rem_ext[l] = {rem_st[k][l], x_st[k][l][CONE_W-1 -: 3]};
				base[l]    = (TRY_W'(sq_st[k][l]) << 2) + (TRY_W'(y_st[k][l]) << 1);
				bound[l]   = (BND_W'(base[l]) << 1) + BND_W'(base[l]) + BND_W'(1);
				take[l]    = rem_ext[l] >= EXT_W'(bound[l]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_st[k+1] <= 1'b0;
			end else if (adv) begin
				vld_st[k+1] <= vld_st[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < 3; l++) begin
					x_st[k+1][l] <= x_st[k][l] << 3;
					if (take[l]) begin
						rem_st[k+1][l] <= REM_W'(rem_ext[l] - EXT_W'(bound[l]));
						y_st[k+1][l]   <= {y_st[k][l][ROOT_W-2:0], 1'b1};
						sq_st[k+1][l]  <= SQ_W'((TRY_W'(sq_st[k][l]) << 2)
							+ (TRY_W'(y_st[k][l]) << 2) + TRY_W'(1));
					end else begin
						rem_st[k+1][l] <= REM_W'(rem_ext[l]);
						y_st[k+1][l]   <= {y_st[k][l][ROOT_W-2:0], 1'b0};
						sq_st[k+1][l]  <= SQ_W'(TRY_W'(sq_st[k][l]) << 2);
					end
				end
			end
		end
	end

	assign out_valid = vld_st[ROOT_W];
	assign root      = y_st[ROOT_W];

endmodule

// ----- sv/r2ok_lab_matrix.sv -----
// ----------------------------------------------------------------------------
// r2ok_lab_matrix
// Cube roots to Oklab: products in stage 1, sum, round and saturate in 2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module r2ok_lab_matrix
	import r2ok_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  root_t              root [3],
	output logic               out_valid,
	output logic [OUT_W-1:0]   lightness,
	output logic signed [OUT_W-1:0] green_red_axis,
	output logic signed [OUT_W-1:0] blue_yellow_axis
);

	localparam int LQ_W = LAB_SUM_W - 32;
	localparam int AQ_W = LAB_SUM_W - 33;

	logic signed [LAB_PROD_W-1:0] prod_s1 [3][3];
	logic                         valid_s1;
	logic signed [LAB_SUM_W-1:0]  sum [3];
	logic signed [LAB_SUM_W-1:0]  w_l, w_a, w_b;
	logic signed [LQ_W-1:0]       lq;
	logic signed [AQ_W-1:0]       aq, bq;
	logic [OUT_W-1:0]             l_sat;
	logic signed [OUT_W-1:0]      a_sat, b_sat;
	logic [OUT_W-1:0]             l_s2;
	logic signed [OUT_W-1:0]      a_s2, b_s2;
	logic                         valid_s2;

	// Saturate a rounded chroma value to signed 16 bits
	function automatic logic signed [OUT_W-1:0] sat_chroma(logic signed [AQ_W-1:0] v);
		logic signed [AQ_W-1:0] hi, lo;
		hi = AQ_W'(32767);
		lo = -AQ_W'(32768);
		if (v > hi) begin
			return OUT_W'(32767);
		end else if (v < lo) begin
			return -OUT_W'(32768);
		end
		return v[OUT_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: signed products of coefficients and roots
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s1[i][j] <= LAB_PROD_W'(LAB_MAT[i][j])
						* LAB_PROD_W'($signed({1'b0, root[j]}));
				end
			end
		end
	end

	// Stage 2: sum rows, round half up from Q.48, saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = LAB_SUM_W'(prod_s1[i][0]) + LAB_SUM_W'(prod_s1[i][1])
				+ LAB_SUM_W'(prod_s1[i][2]);
		end
		w_l = sum[0] + (LAB_SUM_W'(1) <<< 31);
		w_a = sum[1] + (LAB_SUM_W'(1) <<< 32);
		w_b = sum[2] + (LAB_SUM_W'(1) <<< 32);
		lq  = w_l[LAB_SUM_W-1:32];
		aq  = w_a[LAB_SUM_W-1:33];
		bq  = w_b[LAB_SUM_W-1:33];
		if (lq < 0) begin
			l_sat = '0;
		end else if (lq > LQ_W'(65535)) begin
			l_sat = '1;
		end else begin
			l_sat = lq[OUT_W-1:0];
		end
		a_sat = sat_chroma(aq);
		b_sat = sat_chroma(bq);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s2 <= l_sat;
			a_s2 <= a_sat;
			b_s2 <= b_sat;
		end
	end

	assign out_valid        = valid_s2;
	assign lightness        = l_s2;
	assign green_red_axis   = a_s2;
	assign blue_yellow_axis = b_s2;

endmodule

// ----- sv/r2ok_checker.sv -----
// ----------------------------------------------------------------------------
// r2ok_checker
// Port-level checks of the converter's flow control, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module r2ok_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] lightness,
	input logic [15:0] green_red_axis,
	input logic [15:0] blue_yellow_axis
);

	// Reset empties the pipeline
	`R2OK_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !out_valid)

	// Input stalls only behind a waiting result
	`R2OK_ASSERT(a_stall_cause, clk, arst_n, !in_ready |-> (out_valid && !out_ready))

	// A waiting result holds
	`R2OK_ASSERT(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(lightness) && $stable(green_red_axis) && $stable(blue_yellow_axis)))

endmodule

bind rgb_to_oklab_converter r2ok_checker u_r2ok_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_ready         (rgb.ready),
	.out_valid        (lab.valid),
	.out_ready        (lab.ready),
	.lightness        (lab.lightness),
	.green_red_axis   (lab.green_red_axis),
	.blue_yellow_axis (lab.blue_yellow_axis)
);

// ----- tb/rgb_to_oklab_converter_tb.sv -----
// ----------------------------------------------------------------------------
// rgb_to_oklab_converter_tb
// Self-checking bench for the linear RGB to Oklab pipeline.
// ----------------------------------------------------------------------------
// A directed table of pixels is sent first, then random pixels in several
// flow-control phases. Every beat taken by the block is run through a local
// fixed-point model, and the results are compared in order against it.
`timescale 1ns / 1ps

module rgb_to_oklab_converter_tb;
	import r2ok_pkg::*;

	typedef struct packed {
		logic [15:0]        lightness;
		logic signed [15:0] green_red_axis;
		logic signed [15:0] blue_yellow_axis;
	} lab_pixel_t;

	typedef struct {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		bit          known;
		lab_pixel_t  lab;
	} pixel_row_t;

	typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH, PH_HOLDOFF} phase_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int RANDOM_ITEMS   = 1200;

	logic clk;
	logic arst_n;

	r2ok_rgb_if #(.CHANNEL_BITS(16)) rgb ();
	r2ok_lab_if                      lab ();

	rgb_to_oklab_converter #(.CHANNEL_BITS(16)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rgb    (rgb),
		.lab    (lab)
	);

	lab_pixel_t expected_lab_q[$];
	lab_pixel_t pinned_lab_q[$];
	bit         pinned_flag_q[$];
	pixel_row_t pixel_table[$];
	phase_t     phase;
	int         error_count;
	int         quiet_cycles;
	bit         holdoff_active;
	bit         holdoff_done;

	// Exact floor of the cube root of a Q0.60 cone value
	function automatic logic [19:0] cone_root(logic [59:0] x);
		logic [19:0] r;
		logic [19:0] t;
		logic [63:0] cube;
		r = '0;
		for (int i = 19; i >= 0; i--) begin
			t = r | (20'd1 << i);
			cube = 64'(t) * 64'(t) * 64'(t);
			if (cube <= 64'(x))
				r = t;
		end
		return r;
	endfunction

	// Round half up from Q.48 and shift
	function automatic longint round_down(longint v, int s);
		longint w;
		w = v + (longint'(1) << (s - 1));
		return w >>> s;
	endfunction

	function automatic lab_pixel_t oklab_of(logic [15:0] r, logic [15:0] g, logic [15:0] b);
		logic [63:0] acc;
		logic [19:0] root [3];
		longint      sum;
		longint      v [3];
		logic [15:0] ch [3];
		lab_pixel_t  res;
		ch[0] = r;
		ch[1] = g;
		ch[2] = b;
		for (int i = 0; i < 3; i++) begin
			acc = '0;
			for (int j = 0; j < 3; j++)
				acc += 64'(LMS_MAT[i][j]) * 64'(ch[j]);
			acc = acc << (LMS_FRAC - 16);
			if (acc > 64'h0FFF_FFFF_FFFF_FFFF)
				acc = 64'h0FFF_FFFF_FFFF_FFFF;
			root[i] = cone_root(acc[59:0]);
		end
		for (int i = 0; i < 3; i++) begin
			sum = 0;
			for (int j = 0; j < 3; j++)
				sum += longint'(LAB_MAT[i][j]) * longint'({1'b0, root[j]});
			v[i] = round_down(sum, (i == 0) ? 32 : 33);
		end
		res.lightness        = (v[0] < 0) ? 16'd0 : (v[0] > 65535) ? 16'hFFFF : v[0][15:0];
		res.green_red_axis   = (v[1] < -32768) ? -16'sd32768 :
			(v[1] > 32767) ? 16'sd32767 : v[1][15:0];
		res.blue_yellow_axis = (v[2] < -32768) ? -16'sd32768 :
			(v[2] > 32767) ? 16'sd32767 : v[2][15:0];
		return res;
	endfunction

	function automatic pixel_row_t row(logic [15:0] r, logic [15:0] g, logic [15:0] b,
			bit known = 0, logic [15:0] lv = 0, logic [15:0] av = 0, logic [15:0] bv = 0);
		pixel_row_t p;
		p.red   = r;
		p.green = g;
		p.blue  = b;
		p.known = known;
		p.lab   = '{lv, av, bv};
		return p;
	endfunction

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Sender: directed table, then random pixels
	initial begin
		pixel_row_t p;
		int         n;
		rgb.valid = 1'b0;
		rgb.red   = '0;
		rgb.green = '0;
		rgb.blue  = '0;
		lab.ready = 1'b0;
		arst_n    = 1'b0;
		phase     = PH_FREE;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// black read straight off the formats
		pixel_table.push_back(row(16'h0000, 16'h0000, 16'h0000, 1, 16'h0000, 16'h0000, 16'h0000));
		pixel_table.push_back(row(16'hFFFF, 16'hFFFF, 16'hFFFF));
		pixel_table.push_back(row(16'hFFFF, 16'h0000, 16'h0000));
		pixel_table.push_back(row(16'h0000, 16'hFFFF, 16'h0000));
		pixel_table.push_back(row(16'h0000, 16'h0000, 16'hFFFF));
		pixel_table.push_back(row(16'hFFFF, 16'hFFFF, 16'h0000));
		pixel_table.push_back(row(16'h0000, 16'hFFFF, 16'hFFFF));
		pixel_table.push_back(row(16'hFFFF, 16'h0000, 16'hFFFF));
		pixel_table.push_back(row(16'h0001, 16'h0000, 16'h0000));
		pixel_table.push_back(row(16'h0000, 16'h0001, 16'h0000));
		pixel_table.push_back(row(16'h0000, 16'h0000, 16'h0001));
		pixel_table.push_back(row(16'h0001, 16'h0001, 16'h0001));
		pixel_table.push_back(row(16'h8000, 16'h8000, 16'h8000));
		pixel_table.push_back(row(16'h7FFF, 16'h7FFF, 16'h7FFF));
		pixel_table.push_back(row(16'hAAAA, 16'h5555, 16'hAAAA));
		pixel_table.push_back(row(16'h5555, 16'hAAAA, 16'h5555));
		pixel_table.push_back(row(16'hFFFF, 16'h0001, 16'h0000));
		pixel_table.push_back(row(16'h0000, 16'h0001, 16'hFFFF));

		@(posedge clk);
		foreach (pixel_table[i]) begin
			pinned_flag_q.push_back(pixel_table[i].known);
			pinned_lab_q.push_back(pixel_table[i].lab);
			rgb.valid <= 1'b1;
			rgb.red   <= pixel_table[i].red;
			rgb.green <= pixel_table[i].green;
			rgb.blue  <= pixel_table[i].blue;
			do @(posedge clk); while (!rgb.ready);
		end

		// Random part, phases in turn
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			n = k / (RANDOM_ITEMS / 5);
			phase = (n == 0) ? PH_FREE : (n == 1) ? PH_SRC_IDLE : (n == 2) ? PH_SNK_STALL :
				(n == 3) ? PH_BOTH : PH_HOLDOFF;
			if ((phase == PH_SRC_IDLE || phase == PH_BOTH) &&
					$urandom_range(99) < ((phase == PH_BOTH) ? 16 : 62)) begin
				rgb.valid <= 1'b0;
				@(posedge clk);
				k--;
				continue;
			end
			p = row(16'($urandom()), 16'($urandom()), 16'($urandom()));
			// corner-heavy channels now and then
			if ($urandom_range(7) == 0) p.red = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			if ($urandom_range(7) == 0) p.green = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			if ($urandom_range(7) == 0) p.blue = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			pinned_flag_q.push_back(1'b0);
			pinned_lab_q.push_back('0);
			rgb.valid <= 1'b1;
			rgb.red   <= p.red;
			rgb.green <= p.green;
			rgb.blue  <= p.blue;
			do @(posedge clk); while (!rgb.ready);
		end
		rgb.valid <= 1'b0;

		// Drain
		while (expected_lab_q.size() != 0 || holdoff_active) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Receiver: stall pattern per phase, one long hold-off
	initial begin
		int stall_pct;
		holdoff_active = 1'b0;
		holdoff_done   = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (phase == PH_HOLDOFF && !holdoff_done && expected_lab_q.size() > 8) begin
				holdoff_active = 1'b1;
				lab.ready <= 1'b0;
				repeat (200) @(posedge clk);
				holdoff_active = 1'b0;
				holdoff_done   = 1'b1;
			end
			stall_pct = (phase == PH_SNK_STALL) ? 62 : (phase == PH_BOTH) ? 16 : 0;
			lab.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Predict on accepted input beats, check accepted output beats
	always @(posedge clk) begin
		lab_pixel_t want;
		lab_pixel_t got;
		if (arst_n && rgb.valid && rgb.ready) begin
			want = oklab_of(rgb.red, rgb.green, rgb.blue);
			if (pinned_flag_q.pop_front() && pinned_lab_q[0] != want) begin
				$error("table row: lightness exp %0d got %0d, green_red_axis exp %0d got %0d, blue_yellow_axis exp %0d got %0d",
					pinned_lab_q[0].lightness, want.lightness,
					pinned_lab_q[0].green_red_axis, want.green_red_axis,
					pinned_lab_q[0].blue_yellow_axis, want.blue_yellow_axis);
				error_count++;
			end
			void'(pinned_lab_q.pop_front());
			expected_lab_q.push_back(want);
		end
		if (arst_n && lab.valid && lab.ready) begin
			got = '{lab.lightness, lab.green_red_axis, lab.blue_yellow_axis};
			if (expected_lab_q.size() == 0) begin
				$error("unexpected output beat");
				error_count++;
			end else begin
				want = expected_lab_q.pop_front();
				if (got.lightness !== want.lightness) begin
					$error("lightness exp %0d got %0d", want.lightness, got.lightness);
					error_count++;
				end
				if (got.green_red_axis !== want.green_red_axis) begin
					$error("green_red_axis exp %0d got %0d", want.green_red_axis,
						got.green_red_axis);
					error_count++;
				end
				if (got.blue_yellow_axis !== want.blue_yellow_axis) begin
					$error("blue_yellow_axis exp %0d got %0d", want.blue_yellow_axis,
						got.blue_yellow_axis);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((rgb.valid && rgb.ready) || (lab.valid && lab.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial quiet_cycles = 0;
	initial error_count = 0;

endmodule

// ----- filelist.f -----
+incdir+sv
sv/r2ok_pkg.sv
sv/r2ok_rgb_if.sv
sv/r2ok_lab_if.sv
sv/r2ok_lms_matrix.sv
sv/r2ok_cbrt_pipe.sv
sv/r2ok_lab_matrix.sv
sv/rgb_to_oklab_converter.sv
sv/r2ok_checker.sv
tb/rgb_to_oklab_converter_tb.sv
